/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the screen-space error test.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PSE_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pse assertion failed");
`define PSE_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("pse assertion failed");
`else
`define PSE_ASSERT(name, clk, rstn, prop)
`define PSE_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

/* hw/rtl/pse_pkg.sv */
// Package with widths, register indices and latency helpers for the error test.
`default_nettype none
package pse_pkg;
    localparam int CoordW = 32;
    localparam int CoefW  = 16;
    localparam int ViewW  = 52;
    localparam int RsW    = 48;
    localparam int CvW    = 39;
    localparam int ReW    = 80;
    localparam int PW     = 119;
    localparam int D2W    = 104;
    localparam int R2W    = 108;
    localparam int TolW   = 10;
    localparam logic [TolW-1:0] TOL_SQ = 10'd625;

    typedef enum logic [2:0] {
        CFG_ROT_X, CFG_ROT_Y, CFG_ROT_Z, CFG_SHIFT_XY,
        CFG_SHIFT_Z, CFG_RADIUS_SCALE, CFG_CLIP_SCALE, CFG_VIEW_SIZE
    } cfg_idx_t;

    // Cycles through pse_mul for an operand of the given width on its first port.
    function automatic int mul_lat(input int wa);
        return 2 + $clog2((wa + 31) / 32);
    endfunction
endpackage
`default_nettype wire

/* hw/rtl/pse_mul.sv */
// Pipelined wide multiplier built from 32 by 32 bit partial products and an adder tree.
`default_nettype none
module pse_mul import pse_pkg::*; #(
    parameter int WA = 32,
    parameter int WB = 32
) (
    input  wire logic             aclk,
    input  wire logic             ce,
    input  wire logic [WA-1:0]    a,
    input  wire logic [WB-1:0]    b,
    output logic [WA+WB-1:0]      p
);
    localparam int NA = (WA + 31) / 32;
    localparam int NB = (WB + 31) / 32;
    localparam int LV = $clog2(NA);
    localparam int NT = 1 << LV;
    localparam int WI = 32 * (NT + NB);

    logic [32*NT-1:0] a_pad;
    logic [32*NB-1:0] b_pad;
    logic [63:0]      pp_reg  [NT][NB];
    logic [WI-1:0]    even_v  [NT];
    logic [WI-1:0]    odd_v   [NT];
    logic [WI-1:0]    lvl_reg [LV+1][NT];

    assign a_pad = (32*NT)'(a);
    assign b_pad = (32*NB)'(b);

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < NT; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= 64'(a_pad[32*i +: 32]) * 64'(b_pad[32*j +: 32]);
                end
            end
        end
    end

    // Products of even and odd digit pairs do not overlap, so each set is a plain merge.
    always_comb begin
        for (int i = 0; i < NT; i++) begin
            even_v[i] = '0;
            odd_v[i]  = '0;
            for (int j = 0; j < NB; j++) begin
                if ((j & 1) == 0) begin
                    even_v[i] = even_v[i] | (WI'(pp_reg[i][j]) << (32 * (i + j)));
                end else begin
                    odd_v[i] = odd_v[i] | (WI'(pp_reg[i][j]) << (32 * (i + j)));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < NT; i++) begin
                lvl_reg[0][i] <= even_v[i] + odd_v[i];
            end
        end
    end

    for (genvar k = 1; k <= LV; k++) begin : g_tree
        for (genvar i = 0; i < (NT >> k); i++) begin : g_node
            always_ff @(posedge aclk) begin
                if (ce) begin
                    lvl_reg[k][i] <= lvl_reg[k-1][2*i] + lvl_reg[k-1][2*i+1];
                end
            end
        end
    end

    assign p = lvl_reg[LV][0][WA+WB-1:0];
endmodule
`default_nettype wire

/* hw/rtl/pse_dly.sv */
// Delay line that keeps side data in step with the multiplier pipelines.
`default_nettype none
module pse_dly import pse_pkg::*; #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  wire logic         aclk,
    input  wire logic         ce,
    input  wire logic [W-1:0] d,
    output logic [W-1:0]      q
);
    logic [W-1:0] tap_reg [D];

    always_ff @(posedge aclk) begin
        if (ce) begin
            tap_reg[0] <= d;
            for (int i = 1; i < D; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[D-1];
endmodule
`default_nettype wire

/* hw/rtl/projected_sphere_error_test.sv */
// The datapath holds 13 register stages between a taken input word and its offered result word.
// Throughput: one word per cycle; the whole pipeline advances whenever the output
// register is empty or taken, so a stall holds every stage in place.
// The longest path is the 119 by 119 bit squaring of the projected error, four stages deep.
// Reset (aresetn low, synchronous) empties the pipeline and loads identity rotation,
// zero translation, unit scales and a view size of 1024.
`default_nettype none
`include "assert_macros.svh"
module projected_sphere_error_test import pse_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // center_x, center_y, center_z, radius, geom_error (32 bits each, from bit 0)
    input  wire logic [159:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tolerance flag, camera-inside flag, six zero bits
    output logic [7:0]        m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_data
);
    localparam int LatRs  = mul_lat(RsW);
    localparam int TRe    = 1 + LatRs;
    localparam int TSq    = 3 + mul_lat(ViewW);
    localparam int TD2    = TSq + 1;
    localparam int TP     = TRe + mul_lat(CvW);
    localparam int TDiff  = TD2 + 1;
    localparam int TLhs   = TP + mul_lat(PW);
    localparam int TRhs   = TDiff + mul_lat(D2W);
    localparam int TOut   = TRhs + 1;

    logic [47:0] rot_reg [3];
    logic [63:0] shift_xy_reg;
    logic [31:0] shift_z_reg;
    logic [15:0] rscale_reg;
    logic [23:0] clip_reg;
    logic [14:0] view_reg;

    logic        ce;
    logic [TOut:1] vld_reg;

    logic signed [47:0]      prod_reg [3][3];
    logic [RsW-1:0]          rs_reg;
    logic [CvW-1:0]          cv_reg;
    logic [31:0]             err_reg;
    logic signed [ViewW-1:0] v_reg [3];
    logic [ViewW-1:0]        mag_reg [3];
    logic [2*ViewW-1:0]      sq [3];
    logic [ReW-1:0]          re;
    logic [2*RsW-1:0]        rr;
    logic [CvW-1:0]          cv_d;
    logic [2*RsW-1:0]        rr_d;
    logic [PW-1:0]           p;
    logic [D2W-1:0]          d2_reg;
    logic [R2W-1:0]          r2;
    logic                    inside_reg;
    logic [D2W-1:0]          diff_reg;
    logic [2*PW-1:0]         lhs;
    logic [2*PW-1:0]         lhs_d;
    logic [D2W+TolW-1:0]     rhs;
    logic                    inside_d;
    logic                    within_out_reg;
    logic                    inside_out_reg;
    logic signed [31:0]      shift_v [3];

    assign cfg_ready = 1'b1;
    assign ce        = m_tready || !vld_reg[TOut];
    assign s_tready  = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_reg[0]   <= 48'd16384;
            rot_reg[1]   <= 48'd16384 << 16;
            rot_reg[2]   <= 48'd16384 << 32;
            shift_xy_reg <= '0;
            shift_z_reg  <= '0;
            rscale_reg   <= 16'd256;
            clip_reg     <= 24'd65536;
            view_reg     <= 15'd1024;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROT_X:        rot_reg[0]   <= cfg_data[47:0];
                CFG_ROT_Y:        rot_reg[1]   <= cfg_data[47:0];
                CFG_ROT_Z:        rot_reg[2]   <= cfg_data[47:0];
                CFG_SHIFT_XY:     shift_xy_reg <= cfg_data;
                CFG_SHIFT_Z:      shift_z_reg  <= cfg_data[31:0];
                CFG_RADIUS_SCALE: rscale_reg   <= cfg_data[15:0];
                CFG_CLIP_SCALE:   clip_reg     <= cfg_data[23:0];
                CFG_VIEW_SIZE:    view_reg     <= cfg_data[14:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[TOut-1:1], s_tvalid};
        end
    end

    assign shift_v[0] = shift_xy_reg[31:0];
    assign shift_v[1] = shift_xy_reg[63:32];
    assign shift_v[2] = shift_z_reg;

    // Stage 1: coefficient products, scaled radius and the clip-by-viewport factor.
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[r][c] <= $signed(rot_reg[r][16*c +: 16])
                                    * $signed(s_tdata[32*c +: 32]);
                end
            end
            rs_reg  <= RsW'(s_tdata[127:96]) * RsW'(rscale_reg);
            cv_reg  <= CvW'(clip_reg) * CvW'(view_reg);
            err_reg <= s_tdata[159:128];
        end
    end

    // Stages 2 and 3: view coordinates in Q.30, then their magnitudes.
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int r = 0; r < 3; r++) begin
                v_reg[r] <= ViewW'(prod_reg[r][0]) + ViewW'(prod_reg[r][1])
                          + ViewW'(prod_reg[r][2]) + (ViewW'(shift_v[r]) <<< 14);
                mag_reg[r] <= v_reg[r][ViewW-1] ? ViewW'(-v_reg[r]) : ViewW'(v_reg[r]);
            end
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_sq
        pse_mul #(.WA(ViewW), .WB(ViewW)) u_sq (
            .aclk(aclk), .ce(ce), .a(mag_reg[r]), .b(mag_reg[r]), .p(sq[r])
        );
    end

    pse_mul #(.WA(RsW), .WB(32)) u_re (
        .aclk(aclk), .ce(ce), .a(rs_reg), .b(err_reg), .p(re)
    );
    pse_mul #(.WA(RsW), .WB(RsW)) u_rr (
        .aclk(aclk), .ce(ce), .a(rs_reg), .b(rs_reg), .p(rr)
    );
    pse_dly #(.W(CvW), .D(LatRs)) u_cv_dly (
        .aclk(aclk), .ce(ce), .d(cv_reg), .q(cv_d)
    );
    pse_dly #(.W(2*RsW), .D(TD2 - TRe)) u_rr_dly (
        .aclk(aclk), .ce(ce), .d(rr), .q(rr_d)
    );
    pse_mul #(.WA(CvW), .WB(ReW)) u_p (
        .aclk(aclk), .ce(ce), .a(cv_d), .b(re), .p(p)
    );

    assign r2 = {rr_d, 12'd0};

    // Squared distance, then the inside test and the distance margin.
    always_ff @(posedge aclk) begin
        if (ce) begin
            d2_reg     <= D2W'(sq[0]) + D2W'(sq[1]) + D2W'(sq[2]);
            inside_reg <= R2W'(d2_reg) <= r2;
            diff_reg   <= d2_reg - r2[D2W-1:0];
        end
    end

    pse_mul #(.WA(PW), .WB(PW)) u_lhs (
        .aclk(aclk), .ce(ce), .a(p), .b(p), .p(lhs)
    );
    pse_mul #(.WA(D2W), .WB(TolW)) u_rhs (
        .aclk(aclk), .ce(ce), .a(diff_reg), .b(TOL_SQ), .p(rhs)
    );
    pse_dly #(.W(2*PW), .D(TRhs - TLhs)) u_lhs_dly (
        .aclk(aclk), .ce(ce), .d(lhs), .q(lhs_d)
    );
    pse_dly #(.W(1), .D(TRhs - TDiff)) u_in_dly (
        .aclk(aclk), .ce(ce), .d(inside_reg), .q(inside_d)
    );

    // The margin is lifted from Q.60 to Q.112 to meet the squared error.
    always_ff @(posedge aclk) begin
        if (ce) begin
            within_out_reg <= !inside_d && (lhs_d < (2*PW)'({rhs, 52'd0}));
            inside_out_reg <= inside_d;
        end
    end

    assign m_tvalid = vld_reg[TOut];
    assign m_tdata  = {6'd0, inside_out_reg, within_out_reg};

    `PSE_ASSERT(a_inside_not_within, aclk, aresetn, (m_tvalid && m_tdata[1]) |-> !m_tdata[0])
    `PSE_ASSERT(a_stall_holds, aclk, aresetn, !ce |=> $stable(vld_reg))
    `PSE_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_tvalid)
endmodule
`default_nettype wire

/* tb/sv/projected_sphere_error_test_tb.sv */
// Self-checking testbench for the projected sphere screen-space error test block.
`default_nettype none
module projected_sphere_error_test_tb import pse_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic tol_ok;
        logic cam_in;
    } verdict_t;

    localparam int DueDepth = 4096;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;

    projected_sphere_error_test u_top (.*);

    // Shadow copy of the registers.
    logic [47:0] rot_x, rot_y, rot_z;
    logic [63:0] sh_xy;
    logic [31:0] sh_z;
    logic [15:0] rscale;
    logic [23:0] cscale;
    logic [14:0] vsize;

    // Expected verdicts, written at the tail and read at the head.
    verdict_t due_mem [DueDepth];
    int  due_head = 0;
    int  due_tail = 0;
    int  failures = 0;
    int  words_sent = 0;
    int  words_seen = 0;
    int  in_sphere_seen = 0;
    int  tol_ok_seen = 0;
    bit  hold_off = 1'b0;

    initial forever #5 aclk = ~aclk;

    initial begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic signed [63:0] view_axis(input logic [47:0] row,
            input logic signed [31:0] cx, input logic signed [31:0] cy,
            input logic signed [31:0] cz, input logic signed [31:0] sh);
        logic signed [63:0] acc;
        acc = 64'(signed'(row[15:0])) * 64'(cx) + 64'(signed'(row[31:16])) * 64'(cy)
            + 64'(signed'(row[47:32])) * 64'(cz);
        return acc + (64'(sh) <<< 14);
    endfunction

    function automatic verdict_t judge_sphere(input logic [159:0] d);
        logic signed [63:0] vx, vy, vz;
        logic [63:0]  ax, ay, az;
        logic [47:0]  rs;
        logic [255:0] dist2, rad2, p, lhs, rhs;
        verdict_t v;
        vx = view_axis(rot_x, d[31:0], d[63:32], d[95:64], sh_xy[31:0]);
        vy = view_axis(rot_y, d[31:0], d[63:32], d[95:64], sh_xy[63:32]);
        vz = view_axis(rot_z, d[31:0], d[63:32], d[95:64], sh_z);
        ax = vx < 0 ? -vx : vx;
        ay = vy < 0 ? -vy : vy;
        az = vz < 0 ? -vz : vz;
        rs = 48'(d[127:96]) * 48'(rscale);
        dist2 = 256'(ax) * ax + 256'(ay) * ay + 256'(az) * az;
        rad2 = (256'(rs) * rs) << 12;
        if (dist2 <= rad2) begin
            v.tol_ok = 1'b0;
            v.cam_in = 1'b1;
        end else begin
            p = 256'(cscale) * rs * vsize * d[159:128];
            lhs = p * p;
            rhs = (dist2 - rad2) * (256'(625) << 52);
            v.tol_ok = lhs < rhs;
            v.cam_in = 1'b0;
        end
        return v;
    endfunction

    // A gap drops tvalid first, so back-to-back words keep it high throughout.
    task automatic pause_random();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) n = 0;
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    task automatic send_sphere(input logic [31:0] cx, input logic [31:0] cy,
            input logic [31:0] cz, input logic [31:0] rad, input logic [31:0] err,
            input bit gaps);
        if (gaps) pause_random();
        s_tdata  <= {err, rad, cz, cy, cx};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        due_mem[due_tail % DueDepth] = judge_sphere({err, rad, cz, cy, cx});
        due_tail++;
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_ROT_X:        rot_x  = val[47:0];
            CFG_ROT_Y:        rot_y  = val[47:0];
            CFG_ROT_Z:        rot_z  = val[47:0];
            CFG_SHIFT_XY:     sh_xy  = val;
            CFG_SHIFT_Z:      sh_z   = val[31:0];
            CFG_RADIUS_SCALE: rscale = val[15:0];
            CFG_CLIP_SCALE:   cscale = val[23:0];
            default:          vsize  = val[14:0];
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (due_tail != due_head) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    // Random rotation row with small or full-range coefficients.
    function automatic logic [47:0] pick_row();
        logic [47:0] r;
        for (int i = 0; i < 3; i++)
            r[i*16 +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                : 16'($signed($urandom_range(0, 32768)) - 16384);
        return r;
    endfunction

    task automatic program_random();
        write_reg(CFG_ROT_X, {16'h0, pick_row()});
        write_reg(CFG_ROT_Y, {16'h0, pick_row()});
        write_reg(CFG_ROT_Z, {16'h0, pick_row()});
        write_reg(CFG_SHIFT_XY, {$urandom, $urandom});
        write_reg(CFG_SHIFT_Z, {32'h0, $urandom});
        write_reg(CFG_RADIUS_SCALE, 64'($urandom_range(0, 65535)));
        write_reg(CFG_CLIP_SCALE, 64'($urandom_range(0, 24'hFFFFFF)));
        write_reg(CFG_VIEW_SIZE, 64'($urandom_range(0, 32767)));
    endtask

    task automatic program_identity();
        write_reg(CFG_ROT_X, 64'd16384);
        write_reg(CFG_ROT_Y, 64'd16384 << 16);
        write_reg(CFG_ROT_Z, 64'd16384 << 32);
        write_reg(CFG_SHIFT_XY, 64'd0);
        write_reg(CFG_SHIFT_Z, 64'd0);
        write_reg(CFG_RADIUS_SCALE, 64'd256);
        write_reg(CFG_CLIP_SCALE, 64'd65536);
        write_reg(CFG_VIEW_SIZE, 64'd1024);
    endtask

    // A single sphere with center, radius and error drawn from moderate ranges.
    task automatic send_plausible(input bit gaps);
        logic [31:0] rad, err;
        rad = $urandom_range(1 << 12, 1 << 20);
        err = $urandom_range(0, 1 << 10);
        send_sphere($signed($urandom_range(0, 1 << 24)) - (1 << 23),
                    $signed($urandom_range(0, 1 << 24)) - (1 << 23),
                    $signed($urandom_range(0, 1 << 26)) - (1 << 25), rad, err, gaps);
    endtask

    task automatic test_reset_defaults();
        send_sphere(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        send_sphere(32'h0, 32'h0, 32'h0000_0001, 32'h0, 32'hFFFF_FFFF, 1'b0);
        send_sphere(32'h0, 32'h0, 32'h0010_0000, 32'h0001_0000, 32'h0000_0100, 1'b0);
        send_sphere(32'h0, 32'h0, 32'h0010_0000, 32'h0010_0000, 32'h0000_0100, 1'b0);
        drain();
    endtask

    task automatic test_extremes();
        send_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 1'b0);
        send_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 1'b0);
        send_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1, 32'h1, 1'b0);
        send_sphere(32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0);
        drain();
        write_reg(CFG_ROT_X, 64'hFFFF_8000_8000_8000);
        write_reg(CFG_ROT_Y, 64'h7FFF_7FFF_7FFF);
        write_reg(CFG_ROT_Z, 64'h8000_7FFF_8000);
        write_reg(CFG_SHIFT_XY, 64'h8000_0000_7FFF_FFFF);
        write_reg(CFG_SHIFT_Z, 64'h8000_0000);
        write_reg(CFG_RADIUS_SCALE, 64'hFFFF);
        write_reg(CFG_CLIP_SCALE, 64'hFF_FFFF);
        write_reg(CFG_VIEW_SIZE, 64'h7FFF);
        send_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 1'b0);
        send_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h1, 1'b0);
        send_sphere(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        drain();
    endtask

    task automatic test_zero_scales();
        program_identity();
        write_reg(CFG_CLIP_SCALE, 64'd0);
        send_sphere(32'h0, 32'h0, 32'h0100_0000, 32'h0001_0000, 32'hFFFF_FFFF, 1'b0);
        drain();
        write_reg(CFG_CLIP_SCALE, 64'd65536);
        write_reg(CFG_VIEW_SIZE, 64'd0);
        send_sphere(32'h0, 32'h0, 32'h0100_0000, 32'h0001_0000, 32'hFFFF_FFFF, 1'b0);
        drain();
        write_reg(CFG_VIEW_SIZE, 64'd16384);
        write_reg(CFG_RADIUS_SCALE, 64'd0);
        send_sphere(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_FFFF, 1'b0);
        send_sphere(32'h0, 32'h0, 32'h0000_0001, 32'h0001_0000, 32'hFFFF_FFFF, 1'b0);
        drain();
    endtask

    task automatic test_backpressure();
        program_identity();
        hold_off = 1'b1;
        for (int i = 0; i < 60; i++) send_plausible(1'b0);
        drain();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 10; phase++) begin
            if (phase % 3 == 0) program_identity();
            else program_random();
            for (int i = 0; i < 107; i++) begin
                if ($urandom_range(0, 4) == 0)
                    send_sphere($urandom, $urandom, $urandom, $urandom, $urandom, 1'b1);
                else
                    send_plausible(1'b1);
            end
            drain();
        end
    endtask

    // Receiver: random ready, plus one long hold-off on request.
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (200) @(negedge aclk);
                hold_off = 1'b0;
            end else if ($urandom_range(0, 39) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(5, 30);
                repeat (n) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (due_tail == due_head) begin
                $error("result word with nothing outstanding: %h", m_tdata);
                failures++;
            end else begin
                want = due_mem[due_head % DueDepth];
                due_head++;
                if (m_tdata[0] !== want.tol_ok) begin
                    $error("tolerance_ok: expected %0b, got %0b", want.tol_ok, m_tdata[0]);
                    failures++;
                end
                if (m_tdata[1] !== want.cam_in) begin
                    $error("camera_inside: expected %0b, got %0b", want.cam_in, m_tdata[1]);
                    failures++;
                end
                if (m_tdata[1]) in_sphere_seen++;
                if (m_tdata[0]) tol_ok_seen++;
            end
        end
    end

    initial begin
        rot_x = 48'd16384;
        rot_y = 48'd16384 << 16;
        rot_z = 48'd16384 << 32;
        sh_xy = '0;
        sh_z = '0;
        rscale = 16'd256;
        cscale = 24'd65536;
        vsize = 15'd1024;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_defaults();
        test_extremes();
        test_zero_scales();
        test_backpressure();
        test_random_settings();
        if (due_tail != due_head) begin
            $error("%0d results never arrived", due_tail - due_head);
            failures++;
        end
        $display("Sent %0d spheres, checked %0d verdicts (%0d within tolerance, %0d inside).",
                 words_sent, words_seen, tol_ok_seen, in_sphere_seen);
        if (failures == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
